// ===== rtl/core/tccs_pkg.sv =====
// ----------------------------------------------------------------------------
// tccs_pkg
// Shared types and constants of the character-cell text console.
// ----------------------------------------------------------------------------
`default_nettype none

package tccs_pkg;

    localparam int COLUMNS_DEFAULT = 80;
    localparam int ROWS_DEFAULT    = 25;

    localparam int CHAR_W  = 8;
    localparam int ATTR_W  = 8;
    localparam int INDEX_W = 11;
    localparam int COL_OUT_W = 7;
    localparam int ROW_OUT_W = 5;

    localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
    localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0a;
    localparam logic [CHAR_W-1:0] RETURN_CHAR  = 8'h0d;
    localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h1f;

    typedef enum logic [1:0] {
        OP_PUT      = 2'd0,
        OP_CLEAR    = 2'd1,
        OP_SET_ATTR = 2'd2,
        OP_READ     = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_FILL,
        ST_IDLE,
        ST_SCROLL,
        ST_POST
    } state_t;

    typedef struct packed {
        logic [ROW_OUT_W-1:0] cursor_row;
        logic [COL_OUT_W-1:0] cursor_col;
        logic [ATTR_W-1:0]    cell_attr;
        logic [CHAR_W-1:0]    cell_char;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/text_console_cursor_scroll.sv =====
// ----------------------------------------------------------------------------
// text_console_cursor_scroll
// Character-cell text console with cursor, wrap, scroll, clear, attribute
// change and cell read, on streaming ports with a registered result.
// ----------------------------------------------------------------------------
// Sequence: put, set attribute and read enter the post state when the item is
// taken and load the registered result once the output register is free; a put
// that scrolls and a clear first sweep the character memory. Items are taken
// one at a time: the sequencer takes an item, loads the result register when
// the output is free, and only then takes the next.
// Reset: a clearing pass over all COLUMNS*ROWS cells; no item is taken before.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_cursor_scroll import tccs_pkg::*; #(
    parameter int COLUMNS = COLUMNS_DEFAULT,
    parameter int ROWS    = ROWS_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,  // op[1:0], char_byte[9:2], attr_value[17:10],
                                       // cell_index[28:18], zero fill
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [31:0] m_tdata   // cell_char[7:0], cell_attr[15:8],
                                       // cursor_col[22:16], cursor_row[27:23], zero fill
);

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int CELL_W = $clog2(CELLS);

    logic              m_tvalid_reg, m_tvalid_next;
    result_t           m_res_reg, m_res_next;
    logic              out_free;
    logic              res_valid;
    result_t           res;
    logic              mem_we;
    logic [CELL_W-1:0] mem_waddr;
    logic [CHAR_W-1:0] mem_wdata;
    logic              mem_re;
    logic [CELL_W-1:0] mem_raddr;
    logic [CHAR_W-1:0] mem_rdata;

    assign out_free = !m_tvalid_reg || m_tready;

    tccs_ctrl #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS),
        .CELLS   (CELLS),
        .CELL_W  (CELL_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (op_t'(s_tdata[1:0])),
        .in_char   (s_tdata[9:2]),
        .in_attr   (s_tdata[17:10]),
        .in_index  (s_tdata[28:18]),
        .out_free  (out_free),
        .res_valid (res_valid),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    tccs_mem #(
        .DEPTH  (CELLS),
        .ADDR_W (CELL_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        m_res_next    = m_res_reg;
        if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        if (res_valid)
        begin
            m_tvalid_next = 1'b1;
            m_res_next    = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_res_reg <= m_res_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0, m_res_reg};

    // A result is only loaded into a free output register.
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> out_free)
        else $error("result loaded over a pending item");

    // One item at a time: no input is taken in the cycle after an accept.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while an item is in progress");

    // A delivered cursor row always lies on the screen.
    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (32'(m_res_reg.cursor_row) < ROWS))
        else $error("cursor row beyond the last line");

endmodule

`default_nettype wire

// ===== rtl/core/tccs_mem.sv =====
// ----------------------------------------------------------------------------
// tccs_mem
// Character store: one write port and one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module tccs_mem import tccs_pkg::*; #(
    parameter int DEPTH  = COLUMNS_DEFAULT * ROWS_DEFAULT,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [CHAR_W-1:0] wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [CHAR_W-1:0] rdata
);

    logic [CHAR_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read data holds while no read is issued.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/tccs_ctrl.sv =====
// ----------------------------------------------------------------------------
// tccs_ctrl
// Sequencer: cursor and attribute state, clear and scroll sweeps over the
// character store, and result formation.
// ----------------------------------------------------------------------------
`default_nettype none

module tccs_ctrl import tccs_pkg::*; #(
    parameter int COLUMNS = COLUMNS_DEFAULT,
    parameter int ROWS    = ROWS_DEFAULT,
    parameter int CELLS   = COLUMNS * ROWS,
    parameter int CELL_W  = $clog2(CELLS)
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire op_t                in_op,
    input  wire logic [CHAR_W-1:0]  in_char,
    input  wire logic [ATTR_W-1:0]  in_attr,
    input  wire logic [INDEX_W-1:0] in_index,
    input  wire logic               out_free,
    output logic                    res_valid,
    output result_t                 res,
    output logic                    mem_we,
    output logic      [CELL_W-1:0]  mem_waddr,
    output logic      [CHAR_W-1:0]  mem_wdata,
    output logic                    mem_re,
    output logic      [CELL_W-1:0]  mem_raddr,
    input  wire logic [CHAR_W-1:0]  mem_rdata
);

    localparam int COL_W = $clog2(COLUMNS);
    localparam int ROW_W = $clog2(ROWS);
    localparam int CNT_W = $clog2(CELLS + 1);
    localparam int MOVED = (ROWS - 1) * COLUMNS;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              fill_reply_reg, fill_reply_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [CNT_W-1:0]  base_reg, base_next;
    logic [ATTR_W-1:0] attr_reg, attr_next;
    op_t               op_reg, op_next;
    logic              idx_ok_reg, idx_ok_next;

    logic              accept;
    logic              is_nl;
    logic              is_cr;
    logic [COL_W:0]    col_inc;
    logic [ROW_W:0]    row_inc;
    logic [CNT_W-1:0]  base_inc;
    logic [COL_W:0]    put_col;
    logic [ROW_W:0]    put_row;
    logic [CNT_W-1:0]  put_base;
    logic [CELL_W-1:0] pos;
    logic [CNT_W:0]    scroll_raddr;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    assign is_nl    = (in_char == NEWLINE_CHAR);
    assign is_cr    = (in_char == RETURN_CHAR);
    assign col_inc  = (COL_W + 1)'(col_reg) + (COL_W + 1)'(1);
    assign row_inc  = (ROW_W + 1)'(row_reg) + (ROW_W + 1)'(1);
    assign base_inc = base_reg + CNT_W'(COLUMNS);
    assign pos      = CELL_W'(base_reg + CNT_W'(col_reg));
    assign scroll_raddr = (CNT_W + 1)'(cnt_reg) + (CNT_W + 1)'(COLUMNS);

    // Cursor after a put, before the bottom-edge check.
    always_comb
    begin
        put_col  = (COL_W + 1)'(col_reg);
        put_row  = (ROW_W + 1)'(row_reg);
        put_base = base_reg;
        if (is_nl)
        begin
            put_col  = '0;
            put_row  = row_inc;
            put_base = base_inc;
        end
        else if (is_cr)
        begin
            put_col = '0;
        end
        else if (col_inc == (COL_W + 1)'(COLUMNS))
        begin
            put_col  = '0;
            put_row  = row_inc;
            put_base = base_inc;
        end
        else
        begin
            put_col = col_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_FILL;
            cnt_reg        <= '0;
            fill_reply_reg <= 1'b0;
            col_reg        <= '0;
            row_reg        <= '0;
            base_reg       <= '0;
            attr_reg       <= RESET_ATTR;
            op_reg         <= OP_PUT;
            idx_ok_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            fill_reply_reg <= fill_reply_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            base_reg       <= base_next;
            attr_reg       <= attr_next;
            op_reg         <= op_next;
            idx_ok_reg     <= idx_ok_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        fill_reply_next = fill_reply_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        base_next       = base_reg;
        attr_next       = attr_reg;
        op_next         = op_reg;
        idx_ok_next     = idx_ok_reg;
        res_valid       = 1'b0;
        mem_we          = 1'b0;
        mem_waddr       = '0;
        mem_wdata       = BLANK_CHAR;
        mem_re          = 1'b0;
        mem_raddr       = '0;

        unique case (state_reg)
            ST_FILL:
            begin
                mem_we    = 1'b1;
                mem_waddr = CELL_W'(cnt_reg);
                cnt_next  = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(CELLS - 1))
                begin
                    cnt_next   = '0;
                    state_next = fill_reply_reg ? ST_POST : ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next     = in_op;
                    idx_ok_next = (32'(in_index) < CELLS);
                    state_next  = ST_POST;
                    unique case (in_op)
                        OP_PUT:
                        begin
                            if (!is_nl && !is_cr)
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = pos;
                                mem_wdata = in_char;
                            end
                            col_next  = COL_W'(put_col);
                            row_next  = ROW_W'(put_row);
                            base_next = put_base;
                            // Leaving the bottom row scrolls the screen up a line.
                            if (put_row == (ROW_W + 1)'(ROWS))
                            begin
                                col_next   = '0;
                                row_next   = ROW_W'(ROWS - 1);
                                base_next  = CNT_W'(MOVED);
                                cnt_next   = '0;
                                state_next = ST_SCROLL;
                            end
                        end
                        OP_CLEAR:
                        begin
                            col_next        = '0;
                            row_next        = '0;
                            base_next       = '0;
                            cnt_next        = '0;
                            fill_reply_next = 1'b1;
                            state_next      = ST_FILL;
                        end
                        OP_SET_ATTR:
                        begin
                            // Every cell always carries the current attribute, so
                            // the store holds characters only and this is one write.
                            attr_next = in_attr;
                        end
                        OP_READ:
                        begin
                            mem_re    = 1'b1;
                            mem_raddr = CELL_W'(in_index);
                        end
                        default:
                        begin
                            state_next = ST_POST;
                        end
                    endcase
                end
            end

            ST_SCROLL:
            begin
                // Read runs one row ahead; each write lands in the cycle after its read.
                if (cnt_reg < CNT_W'(MOVED))
                begin
                    mem_re    = 1'b1;
                    mem_raddr = CELL_W'(scroll_raddr);
                end
                if (cnt_reg != '0)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = CELL_W'(cnt_reg - CNT_W'(1));
                    mem_wdata = (cnt_reg <= CNT_W'(MOVED)) ? mem_rdata : BLANK_CHAR;
                end
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(CELLS))
                begin
                    cnt_next   = '0;
                    state_next = ST_POST;
                end
            end

            ST_POST:
            begin
                if (out_free)
                begin
                    res_valid  = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res            = '0;
        res.cursor_col = COL_OUT_W'(col_reg);
        res.cursor_row = ROW_OUT_W'(row_reg);
        if (op_reg == OP_READ && idx_ok_reg)
        begin
            res.cell_char = mem_rdata;
            res.cell_attr = attr_reg;
        end
    end

endmodule

`default_nettype wire
